### rtl/core/dtok_pkg.sv
// Shared types, constants and codes of the delimiter tokenizer.
package dtok_pkg;

  // Line length and delimiter table geometry
  localparam int unsigned MaxLen     = 4096;
  localparam int unsigned DelimSlots = 8;
  localparam int unsigned PosW       = 13;
  localparam int unsigned CountW     = 4;
  localparam int unsigned CharsW     = 8 * DelimSlots;

  // Result queue geometry
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QLvlW  = $clog2(QDepth + 1);
  localparam int unsigned MaxRes = 3;

  localparam logic [7:0] Blank = 8'h20;

  // Scan mode codes
  localparam logic [1:0] ModeIdle  = 2'd0;
  localparam logic [1:0] ModePlain = 2'd1;
  localparam logic [1:0] ModeMsg   = 2'd2;

  // Result kinds
  localparam logic [1:0] KindEnd   = 2'd0;
  localparam logic [1:0] KindPlain = 2'd1;
  localparam logic [1:0] KindDelim = 2'd2;
  localparam logic [1:0] KindMsg   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] RegTokChars = 2'd0;
  localparam logic [1:0] RegTokCount = 2'd1;
  localparam logic [1:0] RegMsgChars = 2'd2;
  localparam logic [1:0] RegMsgCount = 2'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_line;
  } in_t;

  typedef struct packed {
    logic [1:0]      token_kind;
    logic [PosW-1:0] first_pos;
    logic [PosW-1:0] last_pos;
    logic            run_last;
  } res_t;

  typedef struct packed {
    logic [CharsW-1:0] tok_chars;
    logic [CountW-1:0] tok_count;
    logic [CharsW-1:0] msg_chars;
    logic [CountW-1:0] msg_count;
  } cfg_t;

  typedef struct packed {
    logic [1:0]      mode;
    logic [PosW-1:0] char_pos;
    logic [PosW-1:0] token_start;
    logic [7:0]      open_delim;
  } scan_t;

endpackage

### rtl/core/dtok_step.sv
// Per-character scan step: delimiter match, next scan state and up to three results.
module dtok_step (
  input  dtok_pkg::in_t                          in_i,
  input  dtok_pkg::cfg_t                         cfg_i,
  input  dtok_pkg::scan_t                        st_i,
  output dtok_pkg::scan_t                        st_o,
  output dtok_pkg::res_t [dtok_pkg::MaxRes-1:0]  res_o,
  output logic [dtok_pkg::MaxRes-1:0]            res_vld_o
);

  logic [dtok_pkg::PosW-1:0] prev;
  logic [dtok_pkg::PosW-1:0] p;
  logic                      tok_hit;
  logic                      msg_hit;
  logic                      is_blank;
  logic                      in_plain;

  // Slot i is live when the count exceeds i; counts above the slot total enable all
  always_comb begin
    tok_hit = 1'b0;
    msg_hit = 1'b0;
    for (int i = 0; i < dtok_pkg::DelimSlots; i++) begin
      if (cfg_i.tok_count > dtok_pkg::CountW'(i) &&
          cfg_i.tok_chars[8*i +: 8] == in_i.ch) begin
        tok_hit = 1'b1;
      end
      if (cfg_i.msg_count > dtok_pkg::CountW'(i) &&
          cfg_i.msg_chars[8*i +: 8] == in_i.ch) begin
        msg_hit = 1'b1;
      end
    end
  end

  assign prev     = st_i.char_pos;
  assign p        = (prev < dtok_pkg::PosW'(dtok_pkg::MaxLen)) ?
                    prev + dtok_pkg::PosW'(1) : dtok_pkg::PosW'(dtok_pkg::MaxLen);
  assign is_blank = (in_i.ch == dtok_pkg::Blank);
  assign in_plain = (st_i.mode == dtok_pkg::ModePlain);

  always_comb begin
    st_o          = st_i;
    st_o.char_pos = p;
    res_vld_o     = '0;
    res_o         = '0;

    // Slot 0: plain token closed by this character
    res_o[0].token_kind = dtok_pkg::KindPlain;
    res_o[0].first_pos  = st_i.token_start;
    res_o[0].last_pos   = prev;

    if (st_i.mode == dtok_pkg::ModeMsg) begin
      res_o[1].token_kind = dtok_pkg::KindMsg;
      res_o[1].first_pos  = st_i.token_start;
      if (in_i.ch == st_i.open_delim) begin
        res_vld_o[1]      = 1'b1;
        res_o[1].last_pos = prev;
        st_o.mode         = dtok_pkg::ModeIdle;
      end else begin
        res_vld_o[1]      = in_i.end_of_line;
        res_o[1].last_pos = p;
      end
    end else if (is_blank) begin
      res_vld_o[0] = in_plain;
      st_o.mode    = dtok_pkg::ModeIdle;
    end else if (tok_hit) begin
      res_vld_o[0]        = in_plain;
      res_vld_o[1]        = 1'b1;
      res_o[1].token_kind = dtok_pkg::KindDelim;
      res_o[1].first_pos  = p;
      res_o[1].last_pos   = p;
      st_o.mode           = dtok_pkg::ModeIdle;
    end else if (msg_hit) begin
      res_vld_o[0]        = in_plain;
      st_o.token_start    = p;
      st_o.open_delim     = in_i.ch;
      st_o.mode           = dtok_pkg::ModeMsg;
      res_vld_o[1]        = in_i.end_of_line;
      res_o[1].token_kind = dtok_pkg::KindMsg;
      res_o[1].first_pos  = p;
      res_o[1].last_pos   = p;
    end else begin
      if (st_i.mode == dtok_pkg::ModeIdle) begin
        st_o.token_start = p;
        st_o.mode        = dtok_pkg::ModePlain;
      end
      res_vld_o[1]        = in_i.end_of_line;
      res_o[1].token_kind = dtok_pkg::KindPlain;
      res_o[1].first_pos  = st_o.token_start;
      res_o[1].last_pos   = p;
    end

    // Line end: terminator last, then back to the reset state
    if (in_i.end_of_line) begin
      res_vld_o[2]        = 1'b1;
      res_o[2].token_kind = dtok_pkg::KindEnd;
      st_o                = '0;
      st_o.mode           = dtok_pkg::ModeIdle;
    end

    res_o[0].run_last = ~(res_vld_o[1] | res_vld_o[2]);
    res_o[1].run_last = ~res_vld_o[2];
    res_o[2].run_last = 1'b1;
  end

endmodule

### rtl/core/dtok_resq.sv
// Result queue: up to three results in a cycle in order; one out a cycle if ready.
module dtok_resq (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  dtok_pkg::res_t [dtok_pkg::MaxRes-1:0]    push_data_i,
  input  logic [dtok_pkg::MaxRes-1:0]              push_vld_i,
  output dtok_pkg::res_t                           out_data_o,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [dtok_pkg::QLvlW-1:0]               level_o
);

  dtok_pkg::res_t                mem_q [dtok_pkg::QDepth];
  logic [dtok_pkg::QPtrW-1:0]    wptr_q, wptr_d;
  logic [dtok_pkg::QPtrW-1:0]    rptr_q, rptr_d;
  logic [dtok_pkg::QLvlW-1:0]    level_q, level_d;
  logic [dtok_pkg::QPtrW-1:0]    off [dtok_pkg::MaxRes];
  logic [dtok_pkg::QLvlW-1:0]    npush;
  logic                          pop;

  // Pack valid results densely: each goes after the valid ones before it
  always_comb begin
    npush = '0;
    for (int k = 0; k < dtok_pkg::MaxRes; k++) begin
      off[k] = npush[dtok_pkg::QPtrW-1:0];
      npush  = npush + dtok_pkg::QLvlW'(push_vld_i[k]);
    end
  end

  assign pop     = out_valid_o & out_ready_i;
  assign wptr_d  = wptr_q + npush[dtok_pkg::QPtrW-1:0];
  assign rptr_d  = rptr_q + dtok_pkg::QPtrW'(pop);
  assign level_d = level_q + npush - dtok_pkg::QLvlW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < dtok_pkg::MaxRes; k++) begin
      if (push_vld_i[k]) begin
        mem_q[wptr_q + off[k]] <= push_data_i[k];
      end
    end
  end

  assign out_valid_o = (level_q != '0);
  assign out_data_o  = mem_q[rptr_q];
  assign level_o     = level_q;

endmodule

### rtl/core/delimiter_tokenizer.sv
// Top level of the delimiter tokenizer: configuration, scan state and result queue.
//
//   port group   dir   handshake                  content
//   in_*         in    in_valid_i / in_ready_o    ch, end_of_line
//   out_*        out   out_valid_o / out_ready_i  token_kind, first_pos, last_pos, run_last
//   cfg_*        in    cfg_we_i                   cfg_idx_i, cfg_data_i
//
// One character is taken per cycle while in_ready_o is high; the scan step works out
// its results in the same cycle, and they are registered into a four-entry result queue.
// A character may cause up to three results, which leave one per cycle while
// out_ready_i is high, so the input stalls whenever the queue holds more than one.
// in_ready_o is high while the queue holds at most one result (room for three).
// Reset clears the scan state, the configuration and the queue; no clearing pass.
module delimiter_tokenizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dtok_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dtok_pkg::res_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [dtok_pkg::CharsW-1:0]   cfg_data_i
);

  dtok_pkg::cfg_t                        cfg_q;
  dtok_pkg::scan_t                       scan_q, scan_d;
  dtok_pkg::res_t [dtok_pkg::MaxRes-1:0] step_res;
  logic [dtok_pkg::MaxRes-1:0]           step_vld;
  logic [dtok_pkg::MaxRes-1:0]           push_vld;
  logic [dtok_pkg::QLvlW-1:0]            level;
  logic                                  in_xfer;

  // Configuration writes: unknown indexes cannot occur with a two-bit index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dtok_pkg::RegTokChars: cfg_q.tok_chars <= cfg_data_i;
        dtok_pkg::RegTokCount: cfg_q.tok_count <= cfg_data_i[dtok_pkg::CountW-1:0];
        dtok_pkg::RegMsgChars: cfg_q.msg_chars <= cfg_data_i;
        dtok_pkg::RegMsgCount: cfg_q.msg_count <= cfg_data_i[dtok_pkg::CountW-1:0];
        default:               cfg_q           <= cfg_q;
      endcase
    end
  end

  // Accept a character only while the queue has room for a full burst
  assign in_ready_o = (level <= dtok_pkg::QLvlW'(dtok_pkg::QDepth - dtok_pkg::MaxRes));
  assign in_xfer    = in_valid_i & in_ready_o;

  dtok_step u_step (
    .in_i      (in_data_i),
    .cfg_i     (cfg_q),
    .st_i      (scan_q),
    .st_o      (scan_d),
    .res_o     (step_res),
    .res_vld_o (step_vld)
  );

  // Advance the scan state on each input transfer, hold it otherwise.
  // The all-zero reset value is the idle mode.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else if (in_xfer) begin
      scan_q <= scan_d;
    end
  end

  // Drop the step's results unless the character is actually transferred
  assign push_vld = step_vld & {dtok_pkg::MaxRes{in_xfer}};

  dtok_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_data_i (step_res),
    .push_vld_i  (push_vld),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .level_o     (level)
  );

  // Queue never overfills
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= dtok_pkg::QLvlW'(dtok_pkg::QDepth))
    else $error("result queue level above depth");

  // Line end returns the scan state to idle at position zero
  a_eol_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_data_i.end_of_line) |=>
      (scan_q.mode == dtok_pkg::ModeIdle && scan_q.char_pos == '0))
    else $error("scan state not cleared after line end");

  // An open token never starts beyond the current position
  a_start_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q.token_start <= scan_q.char_pos)
    else $error("token start beyond current position");

  // Positions stay saturated
  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q.char_pos <= dtok_pkg::PosW'(dtok_pkg::MaxLen))
    else $error("character position above line limit");

endmodule

### verif/delimiter_tokenizer_test.sv
// Self-checking testbench for the delimiter tokenizer: directed lines, then random lines.
`timescale 1ns / 1ps

module delimiter_tokenizer_test;
  import dtok_pkg::*;

  localparam int unsigned HalfPeriod   = 5;
  localparam int unsigned ResetCycles  = 9;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned PhaseQuota   = 66;
  localparam int unsigned MaxPrinted   = 40;
  localparam int unsigned CycleLimit   = 1_000_000;

  typedef enum logic {RowChar, RowCfg} row_kind_e;
  typedef enum logic [1:0] {ReadyOpen, ReadyCoin, ReadyPulse} ready_mode_e;

  // One row of the directed plan: a character transfer or a register write.
  // n_pinned >= 0 means the expected tokens are typed in below.
  typedef struct {
    row_kind_e         kind;
    logic [7:0]        ch;
    logic              eol;
    logic [1:0]        idx;
    logic [CharsW-1:0] data;
    int                n_pinned;
    res_t              pin0;
    res_t              pin1;
  } row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  in_t               in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  res_t              out_data_o;
  logic              cfg_we_i    = 1'b0;
  logic [1:0]        cfg_idx_i   = RegTokChars;
  logic [CharsW-1:0] cfg_data_i  = '0;

  delimiter_tokenizer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // Mirror of the register file, as the block should hold it
  logic [CharsW-1:0] tok_chars = '0;
  logic [CountW-1:0] tok_count = '0;
  logic [CharsW-1:0] msg_chars = '0;
  logic [CountW-1:0] msg_count = '0;

  // Mirror of the scan state
  logic [1:0]      scan_mode  = ModeIdle;
  logic [PosW-1:0] pos_now    = '0;
  logic [PosW-1:0] tok_first  = '0;
  logic [7:0]      msg_opener = '0;

  res_t char_tokens[$];  // tokens caused by the character just taken
  res_t due_tokens[$];   // tokens still owed by the block, oldest first
  res_t pinned_q[$];     // typed-in tokens of the current directed row
  bit   use_pinned = 1'b0;
  row_t plan_q[$];

  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  int unsigned sent_items  = 0;
  int unsigned burst_left  = 0;

  ready_mode_e ready_mode = ReadyOpen;
  int unsigned mode_left  = 0;
  int unsigned hold_left  = 0;

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  function automatic res_t mk_token(logic [1:0] kind, int unsigned first, int unsigned last,
                                    logic fin);
    res_t r;
    r.token_kind = kind;
    r.first_pos  = PosW'(first);
    r.last_pos   = PosW'(last);
    r.run_last   = fin;
    return r;
  endfunction

  function automatic void add_token(logic [1:0] kind, logic [PosW-1:0] first,
                                    logic [PosW-1:0] last);
    char_tokens.push_back(mk_token(kind, first, last, 1'b0));
  endfunction

  // Counts above the slot total behave as the slot total; zero disables the set.
  function automatic bit is_member(logic [7:0] c, logic [CharsW-1:0] chars,
                                   logic [CountW-1:0] count);
    int unsigned n;
    n = (count > DelimSlots) ? DelimSlots : count;
    for (int i = 0; i < n; i++) begin
      if (chars[8*i +: 8] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the mirrored scan by one character and collect the tokens it closes.
  function automatic void scan_char(logic [7:0] c, logic eol);
    logic [PosW-1:0] prev;
    logic [PosW-1:0] p;
    res_t            r;
    char_tokens.delete();
    prev    = pos_now;
    p       = (prev < MaxLen) ? prev + 1'b1 : PosW'(MaxLen);
    pos_now = p;

    if (scan_mode == ModeMsg) begin
      // Only the opening byte closes a message, and it is not part of it
      if (c == msg_opener) begin
        add_token(KindMsg, tok_first, prev);
        scan_mode = ModeIdle;
      end else if (eol) begin
        add_token(KindMsg, tok_first, p);
      end
    end else if (c == Blank) begin
      // A blank separates even when it sits in a delimiter slot
      if (scan_mode == ModePlain) add_token(KindPlain, tok_first, prev);
      scan_mode = ModeIdle;
    end else if (is_member(c, tok_chars, tok_count)) begin
      // Token delimiters win over message delimiters
      if (scan_mode == ModePlain) add_token(KindPlain, tok_first, prev);
      add_token(KindDelim, p, p);
      scan_mode = ModeIdle;
    end else if (is_member(c, msg_chars, msg_count)) begin
      if (scan_mode == ModePlain) add_token(KindPlain, tok_first, prev);
      tok_first  = p;
      msg_opener = c;
      scan_mode  = ModeMsg;
      if (eol) add_token(KindMsg, p, p);
    end else begin
      if (scan_mode == ModeIdle) begin
        tok_first = p;
        scan_mode = ModePlain;
      end
      if (eol) add_token(KindPlain, tok_first, p);
    end

    if (eol) begin
      add_token(KindEnd, '0, '0);
      scan_mode  = ModeIdle;
      pos_now    = '0;
      tok_first  = '0;
      msg_opener = '0;
    end

    if (char_tokens.size() > 0) begin
      r          = char_tokens.pop_back();
      r.run_last = 1'b1;
      char_tokens.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, int got, int want);
    err_count++;
    if (err_count <= MaxPrinted) begin
      $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // Compare every output transfer with the oldest token still owed
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_tokens.size() == 0) begin
        report_mismatch("unexpected token, kind", out_data_o.token_kind, -1);
      end else begin
        want = due_tokens.pop_front();
        if (out_data_o.token_kind !== want.token_kind)
          report_mismatch("token_kind", out_data_o.token_kind, want.token_kind);
        if (out_data_o.first_pos !== want.first_pos)
          report_mismatch("first_pos", out_data_o.first_pos, want.first_pos);
        if (out_data_o.last_pos !== want.last_pos)
          report_mismatch("last_pos", out_data_o.last_pos, want.last_pos);
        if (out_data_o.run_last !== want.run_last)
          report_mismatch("run_last", out_data_o.run_last, want.run_last);
      end
    end
  end

  // Watchdog: give up long after the slowest correct run would have finished
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: open stretches, coin flips, and long holds with
  // single-cycle pulses, switching at random so stalls land on every phase.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 2));
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      ReadyOpen: begin
        out_ready_i <= 1'b1;
      end
      ReadyCoin: begin
        out_ready_i <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (hold_left == 0) begin
          out_ready_i <= 1'b1;
          hold_left = $urandom_range(1, 6);
        end else begin
          out_ready_i <= 1'b0;
          hold_left--;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one character; hold valid and payload until the transfer, then
  // record what the block now owes. Bursts end in a gap of random length.
  // Called and returns at a falling edge.
  task automatic send_char(input logic [7:0] c, input logic eol);
    in_t item;
    item.ch          = c;
    item.end_of_line = eol;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    scan_char(c, eol);
    if (use_pinned) begin
      foreach (pinned_q[i]) due_tokens.push_back(pinned_q[i]);
    end else begin
      foreach (char_tokens[i]) due_tokens.push_back(char_tokens[i]);
    end
    sent_items++;
    burst_left--;
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every owed token, then let the pipeline settle.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (due_tokens.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // One register write; only ever issued with the block idle.
  task automatic write_cfg(input logic [1:0] idx, input logic [CharsW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      RegTokChars: tok_chars = data;
      RegTokCount: tok_count = data[CountW-1:0];
      RegMsgChars: msg_chars = data;
      RegMsgCount: msg_count = data[CountW-1:0];
      default: ;
    endcase
  endtask

  // Count word with junk above the count field, which the block must ignore
  function automatic logic [CharsW-1:0] count_word(int unsigned n);
    return {32'($urandom), 28'($urandom), 4'(n)};
  endfunction

  // Mostly letters, with blanks, configured delimiter bytes (any slot, so
  // slots beyond the count show up too) and the odd arbitrary byte.
  function automatic logic [7:0] pick_char();
    int unsigned roll;
    int unsigned slot;
    roll = $urandom_range(0, 99);
    slot = $urandom_range(0, DelimSlots - 1);
    if (roll < 55) return 8'($urandom_range(8'h61, 8'h7A));
    else if (roll < 70) return Blank;
    else if (roll < 82) return tok_chars[8*slot +: 8];
    else if (roll < 94) return msg_chars[8*slot +: 8];
    else return 8'($urandom_range(0, 255));
  endfunction

  // Send a whole line; mark_at, when non-zero, plants a chosen byte there.
  task automatic send_line(input int unsigned len, input int unsigned mark_at,
                           input logic [7:0] mark);
    logic [7:0] c;
    for (int unsigned i = 1; i <= len; i++) begin
      c = (i == mark_at) ? mark : pick_char();
      send_char(c, i == len);
    end
  endtask

  // New register setting, then random lines until the quota of transfers is met.
  task automatic run_phase(input logic [CharsW-1:0] tc, input int unsigned tn,
                           input logic [CharsW-1:0] mc, input int unsigned mn);
    int unsigned start;
    int unsigned len;
    wait_drain();
    write_cfg(RegTokChars, tc);
    write_cfg(RegTokCount, count_word(tn));
    write_cfg(RegMsgChars, mc);
    write_cfg(RegMsgCount, count_word(mn));
    start = sent_items;
    while (sent_items - start < PhaseQuota) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      send_line(len, 0, 8'h00);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed plan builders
  // ---------------------------------------------------------------------------

  function automatic void add_cfg(logic [1:0] idx, logic [CharsW-1:0] data);
    row_t r;
    r          = '{kind: RowCfg, default: '0};
    r.idx      = idx;
    r.data     = data;
    r.n_pinned = -1;
    plan_q.push_back(r);
  endfunction

  function automatic void add_pinned(logic [7:0] c, logic eol, int n, res_t t0, res_t t1);
    row_t r;
    r          = '{kind: RowChar, default: '0};
    r.ch       = c;
    r.eol      = eol;
    r.n_pinned = n;
    r.pin0     = t0;
    r.pin1     = t1;
    plan_q.push_back(r);
  endfunction

  function automatic void add_char(logic [7:0] c, logic eol);
    add_pinned(c, eol, -1, '0, '0);
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    res_t fin_end;
    fin_end = mk_token(KindEnd, 0, 0, 1'b1);

    // Reset defaults: no delimiters at all, so every non-blank is plain.
    add_pinned(Blank, 1'b1, 1, fin_end, '0);                     // blank line
    add_pinned("a", 1'b0, 0, '0, '0);                            // opens, no token yet
    add_pinned("b", 1'b1, 2, mk_token(KindPlain, 1, 2, 1'b0), fin_end);
    add_pinned(8'h00, 1'b1, 2, mk_token(KindPlain, 1, 1, 1'b0), fin_end);
    add_pinned(8'hFF, 1'b1, 2, mk_token(KindPlain, 1, 1, 1'b0), fin_end);

    // Token set ',' ' ' '|'; message set '"' '|' ' ' quote. Blank sits in
    // both sets and '|' in both, to exercise the priorities.
    add_cfg(RegTokChars, {40'd0, "| ,"});
    add_cfg(RegTokCount, 64'd3);
    add_cfg(RegMsgChars, {32'd0, "' |\""});
    add_cfg(RegMsgCount, 64'd4);

    // Plain then delimiter from one transfer, blank separator, delimiter
    // from both sets, message holding foreign delimiters and a blank, and a
    // lone opener on the last character after a plain token.
    add_char("a", 1'b0);
    add_char("b", 1'b0);
    add_char(",", 1'b0);
    add_char(Blank, 1'b0);
    add_char("x", 1'b0);
    add_char("|", 1'b0);
    add_char("\"", 1'b0);
    add_char("q", 1'b0);
    add_char(",", 1'b0);
    add_char("'", 1'b0);
    add_char(Blank, 1'b0);
    add_char("\"", 1'b0);
    add_char("z", 1'b0);
    add_char("'", 1'b1);
    // Message left open at the end of the line
    add_char("\"", 1'b0);
    add_char("k", 1'b1);
    add_pinned("'", 1'b1, 2, mk_token(KindMsg, 1, 1, 1'b0), fin_end);
    add_pinned("|", 1'b1, 2, mk_token(KindDelim, 1, 1, 1'b0), fin_end);
    // Message closed by the line's last character
    add_char("\"", 1'b0);
    add_char("\"", 1'b1);

    // Hold reset for the full count, release it away from the rising edge
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan_q[i]) begin
      if (plan_q[i].kind == RowCfg) begin
        wait_drain();
        write_cfg(plan_q[i].idx, plan_q[i].data);
      end else begin
        pinned_q.delete();
        if (plan_q[i].n_pinned >= 1) pinned_q.push_back(plan_q[i].pin0);
        if (plan_q[i].n_pinned >= 2) pinned_q.push_back(plan_q[i].pin1);
        use_pinned = (plan_q[i].n_pinned >= 0);
        send_char(plan_q[i].ch, plan_q[i].eol);
        use_pinned = 1'b0;
      end
    end

    // Typical setting; spare slots hold bytes that must stay inert.
    run_phase("][)( |;,", 4, "#%&`~|'\"", 3);
    // Counts far above the slot total, random bytes in every slot
    run_phase({32'($urandom), 32'($urandom)}, 15, {32'($urandom), 32'($urandom)}, 15);
    // Both sets disabled
    run_phase('1, 0, '1, 0);
    // Extreme bytes: all token slots 00, all message slots FF
    run_phase('0, DelimSlots, '1, DelimSlots + 1);
    // Anything goes
    run_phase({32'($urandom), 32'($urandom)}, $urandom_range(0, 15),
              {32'($urandom), 32'($urandom)}, $urandom_range(0, 15));

    wait_drain();
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
